[src/spbb_pkg.sv]
// shared types, constants and the arctangent table for the star/polygon bounding box
// used by spbb_div, spbb_cordic and star_polygon_bounding_box
package spbb_pkg;

	localparam int unsigned MAX_POINTS_DEF   = 256;
	localparam int unsigned CORDIC_STEPS_DEF = 16;

	localparam int unsigned NUM_W   = 48;   // dividend width
	localparam int unsigned DEN_W   = 17;   // divisor width
	localparam int unsigned QUO_W   = 32;   // kept quotient bits (binary angle)
	localparam int unsigned TRIG_W  = 34;   // cordic datapath, Q30 signed
	localparam int unsigned COORD_W = 25;   // Q16.8 signed coordinate
	localparam int unsigned RAD_W   = 24;
	localparam int unsigned PC_W    = 16;
	localparam int unsigned ROT_W   = 17;
	localparam int unsigned NPT_W   = 9;    // ceil(count), at most 256
	localparam int unsigned VRT_W   = 10;   // vertex count, at most 512

	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);
	localparam logic signed [COORD_W-1:0] COORD_MIN = -COORD_W'(16777216);
	localparam logic signed [COORD_W-1:0] COORD_MAX = COORD_W'(16777215);
	localparam int DEG_FULL    = 46080;
	localparam int DEG_QUARTER = 11520;

	typedef logic [QUO_W-1:0] angle_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	// arctangent of 2^-i in units of 2^-32 turn
	function automatic logic [31:0] atan_turns(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

[src/star_polygon_bounding_box.sv]
// top level of the star/polygon bounding box: sequencer, multiplier and min/max tracking
// depends on spbb_pkg, spbb_div, spbb_cordic
//
// One transaction in, one out. The block takes an item only when idle. An item
// first runs the serial division of the angle step (48 quotient bits), while
// the start angle is formed meanwhile by a reciprocal multiplication; then each
// vertex is handled in turn: the shared cordic unit is loaded and runs one
// micro-rotation a cycle, then the one multiplier scales x and y in turn and
// the box is updated. A five-point star has ten vertices; a zero point count
// shows an all-zero box. The result waits in an output register; only the
// next result waits behind it.
module star_polygon_bounding_box #(
	parameter int unsigned MAX_POINTS   = spbb_pkg::MAX_POINTS_DEF,
	parameter int unsigned CORDIC_STEPS = spbb_pkg::CORDIC_STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         is_star,
	input  logic [spbb_pkg::PC_W-1:0]    point_count,
	input  logic signed [spbb_pkg::ROT_W-1:0] rotation_deg,
	input  logic [spbb_pkg::RAD_W-1:0]   outer_radius,
	input  logic [spbb_pkg::RAD_W-1:0]   inner_radius,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [spbb_pkg::COORD_W-1:0] box_left,
	output logic signed [spbb_pkg::COORD_W-1:0] box_top,
	output logic [spbb_pkg::COORD_W-1:0] box_width,
	output logic [spbb_pkg::COORD_W-1:0] box_height
);
	import spbb_pkg::*;

	localparam logic [18:0] PC_MAX = 19'(MAX_POINTS * 256);
	localparam int PROD_W = RAD_W + 1 + TRIG_W;
	// start angle = round(deg * 2^22 / 45), with deg = 45 a + b
	localparam logic [31:0] RECIP_45 = 32'd93207;   // ceil(2^22 / 45)
	localparam logic [31:0] TURN_45  = 32'd93206;   // floor(2^22 / 45)
	localparam logic [23:0] RECIP_90 = 24'd2913;    // ceil(2^18 / 90)

	typedef enum logic [2:0] {
		S_IDLE, S_STEP, S_ROT, S_MX, S_MY, S_ACC, S_DONE
	} state_t;

	state_t            state_q;
	logic              out_valid_q;
	logic              zero_q;
	logic              star_q;
	logic [VRT_W-1:0]  verts_q;
	logic [VRT_W-1:0]  vcnt_q;
	logic [RAD_W-1:0]  outer_q;
	logic [RAD_W-1:0]  inner_q;
	logic [15:0]       deg_q;
	logic [9:0]        ang_a_q;
	logic [5:0]        ang_b_q;
	angle_t            angle_q;
	angle_t            step_q;
	logic              div_start_q;
	logic [NUM_W-1:0]  div_num_q;
	logic [DEN_W-1:0]  div_den_q;
	logic              cor_start_q;
	angle_t            cor_angle_q;
	logic signed [PROD_W-1:0] prod_s1;
	coord_t            vx_q;
	coord_t            min_x_q, min_y_q, max_x_q, max_y_q;
	coord_t            left_q, top_q;
	logic [COORD_W-1:0] width_q, height_q;

	logic              div_done;
	angle_t            div_quot;
	logic              cor_done;
	trig_t             cor_cos;
	trig_t             cor_sin;

	// input decode
	logic [DEN_W-1:0]  pc_cl;
	logic [17:0]       pc_sum;
	logic [NPT_W-1:0]  npt;
	logic signed [18:0] rot_t;
	logic [15:0]       deg;
	coord_t            vy;
	logic [RAD_W-1:0]  rad;
	logic signed [PROD_W-1:0] mul_b;
	angle_t            angle_nx;
	logic [31:0]       deg_prod;
	logic [11:0]       frac_x;
	logic [23:0]       frac_p;

	function automatic coord_t scale(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		logic signed [PROD_W-31:0] v;
		r = p + PROD_W'(1 << 29);
		v = (PROD_W-30)'(r >>> 30);
		if (v < (PROD_W-30)'(COORD_MIN))
			return COORD_MIN;
		if (v > (PROD_W-30)'(COORD_MAX))
			return COORD_MAX;
		return COORD_W'(v);
	endfunction

	always_comb begin
		pc_cl  = ({3'b0, point_count} > PC_MAX) ? DEN_W'(PC_MAX) : {1'b0, point_count};
		pc_sum = {1'b0, pc_cl} + 18'd255;
		npt    = NPT_W'(pc_sum >> 8);
		rot_t  = 19'(rotation_deg) - 19'(DEG_QUARTER);
		if (rot_t >= 19'(DEG_FULL))
			deg = 16'(rot_t - 19'(DEG_FULL));
		else if (rot_t >= 0)
			deg = 16'(rot_t);
		else if (rot_t >= -19'(DEG_FULL))
			deg = 16'(rot_t + 19'(DEG_FULL));
		else
			deg = 16'(rot_t + 19'(2 * DEG_FULL));
	end

	assign rad      = (star_q && vcnt_q[0]) ? inner_q : outer_q;
	assign mul_b    = (state_q == S_MX) ? PROD_W'(cor_cos) : PROD_W'(cor_sin);
	assign vy       = scale(prod_s1);
	assign angle_nx = angle_q + step_q;
	assign deg_prod = {16'd0, deg_q} * RECIP_45;
	// rounded fraction of b * 34 / 45
	assign frac_x   = {6'd0, ang_b_q} * 12'd68 + 12'd45;
	assign frac_p   = {12'd0, frac_x} * RECIP_90;

	spbb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num_q),
		.den    (div_den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	spbb_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start_q),
		.angle  (cor_angle_q),
		.done   (cor_done),
		.cosine (cor_cos),
		.sine   (cor_sin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
			cor_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			cor_start_q <= 1'b0;
			if (out_valid_q && out_ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (point_count == '0) begin
							state_q <= S_DONE;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= S_STEP;
						end
					end
				end
				S_STEP: begin
					if (div_done) begin
						cor_start_q <= 1'b1;
						state_q     <= S_ROT;
					end
				end
				S_ROT: begin
					if (cor_done)
						state_q <= S_MX;
				end
				S_MX: state_q <= S_MY;
				S_MY: state_q <= S_ACC;
				S_ACC: begin
					if (vcnt_q == verts_q - 1'b1) begin
						state_q <= S_DONE;
					end else begin
						cor_start_q <= 1'b1;
						state_q     <= S_ROT;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				star_q    <= is_star;
				verts_q   <= is_star ? {npt, 1'b0} : VRT_W'(npt);
				outer_q   <= outer_radius;
				inner_q   <= inner_radius;
				zero_q    <= (point_count == '0);
				deg_q     <= deg;
				if (is_star) begin
					div_num_q <= NUM_W'(64'd1 << 39) + NUM_W'(pc_cl >> 1);
					div_den_q <= pc_cl;
				end else begin
					div_num_q <= NUM_W'(64'd1 << 32) + NUM_W'(npt >> 1);
					div_den_q <= DEN_W'(npt);
				end
			end
			S_STEP: begin
				// start angle settles through ang_a_q, ang_b_q and angle_q, long before the division ends
				ang_a_q <= 10'(deg_prod >> 22);
				ang_b_q <= 6'(deg_q - {6'd0, ang_a_q} * 16'd45);
				angle_q <= {ang_a_q, 22'd0} + {26'd0, ang_b_q} * TURN_45
					+ 32'(frac_p >> 18);
				if (div_done) begin
					step_q      <= div_quot;
					vcnt_q      <= '0;
					cor_angle_q <= angle_q;
				end
			end
			S_MX: prod_s1 <= $signed({1'b0, rad}) * mul_b;
			S_MY: begin
				vx_q    <= scale(prod_s1);
				prod_s1 <= $signed({1'b0, rad}) * mul_b;
			end
			S_ACC: begin
				// first vertex seeds the box
				if (vcnt_q == '0 || vx_q < min_x_q) min_x_q <= vx_q;
				if (vcnt_q == '0 || vy < min_y_q)   min_y_q <= vy;
				if (vcnt_q == '0 || vx_q > max_x_q) max_x_q <= vx_q;
				if (vcnt_q == '0 || vy > max_y_q)   max_y_q <= vy;
				angle_q     <= angle_nx;
				cor_angle_q <= angle_nx;
				vcnt_q      <= vcnt_q + 1'b1;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					if (zero_q) begin
						left_q   <= '0;
						top_q    <= '0;
						width_q  <= '0;
						height_q <= '0;
					end else begin
						left_q   <= min_x_q;
						top_q    <= min_y_q;
						width_q  <= COORD_W'(max_x_q - min_x_q);
						height_q <= COORD_W'(max_y_q - min_y_q);
					end
				end
			end
			default: ;
		endcase
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign box_left   = left_q;
	assign box_top    = top_q;
	assign box_width  = width_q;
	assign box_height = height_q;

endmodule

[src/spbb_div.sv]
// restoring divider, one quotient bit per cycle, low 32 quotient bits kept
// depends on spbb_pkg
module spbb_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [spbb_pkg::NUM_W-1:0] num,
	input  logic [spbb_pkg::DEN_W-1:0] den,
	output logic                       done,
	output spbb_pkg::angle_t           quot
);
	import spbb_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	angle_t           quot_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   diff;
	logic             fits;

	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quot_q <= {quot_q[QUO_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

[src/spbb_cordic.sv]
// rotation-mode cordic, one micro-rotation per cycle with separate shifters for x and y
// depends on spbb_pkg
module spbb_cordic #(
	parameter int unsigned STEPS = spbb_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  spbb_pkg::angle_t  angle,
	output logic              done,
	output spbb_pkg::trig_t   cosine,
	output spbb_pkg::trig_t   sine
);
	import spbb_pkg::*;

	localparam int IT_W = $clog2(STEPS);

	logic            busy_q;
	logic            done_q;
	logic            flip_q;
	logic [IT_W-1:0] iter_q;
	trig_t           x_q;
	trig_t           y_q;
	trig_t           z_q;
	trig_t           dx;
	trig_t           dy;
	trig_t           at;
	logic            flip;

	assign flip = angle[31] ^ angle[30];
	assign dx   = y_q >>> iter_q;
	assign dy   = x_q >>> iter_q;
	assign at   = TRIG_W'(atan_turns(5'(iter_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == IT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// left half plane: turn by half a turn, negate at the end
			flip_q <= flip;
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= TRIG_W'($signed({angle[31] ^ flip, angle[30:0]}));
		end else if (busy_q) begin
			if (!z_q[TRIG_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done   = done_q;
	assign cosine = flip_q ? -x_q : x_q;
	assign sine   = flip_q ? -y_q : y_q;

endmodule

[tb/sv/tb.sv]
// testbench for star_polygon_bounding_box: directed and random shapes against a predictor
// depends on spbb_pkg and the star_polygon_bounding_box rtl
module tb;
	import spbb_pkg::*;

	localparam int NUM_RANDOM = 480;
	localparam longint CYCLE_LIMIT = 20000000;

	typedef struct {
		coord_t left;
		coord_t top;
		logic [COORD_W-1:0] width;
		logic [COORD_W-1:0] height;
	} box_t;

	class box_scoreboard;
		box_t pending_boxes[$];
		int errors;
		longint atan_lut[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

		function void rotate(logic [31:0] ang, output longint c, output longint s);
			logic flip;
			longint x, y, z, dx, dy;
			flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
			x = 652032874;
			y = 0;
			if (flip)
				ang = ang + 32'h80000000;
			z = longint'($signed(ang));
			for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_lut[i];
				end else begin
					x += dx; y -= dy; z += atan_lut[i];
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function longint scale(longint r, longint t);
			longint v;
			v = (r * t + (64'sd1 <<< 29)) >>> 30;
			if (v < -16777216) v = -16777216;
			if (v > 16777215) v = 16777215;
			return v;
		endfunction

		function void note_shape(logic star, logic [15:0] pc_in, logic signed [16:0] rot,
				logic [23:0] outer, logic [23:0] inner);
			longint unsigned pc, n, verts, stepw, d;
			longint dd, c, s, r, vx, vy, mnx, mny, mxx, mxy;
			logic [31:0] ang, step;
			box_t b;
			b = '{default: '0};
			if (pc_in != 0) begin
				pc = pc_in;
				if (pc > MAX_POINTS_DEF * 256)
					pc = MAX_POINTS_DEF * 256;
				n = (pc + 255) >> 8;
				dd = (longint'(rot) - DEG_QUARTER) % DEG_FULL;
				if (dd < 0) dd += DEG_FULL;
				d = dd;
				ang = 32'(((d << 32) + DEG_FULL / 2) / DEG_FULL);
				if (star) begin
					stepw = ((64'd1 << 39) + pc / 2) / pc;
					verts = 2 * n;
				end else begin
					stepw = ((64'd1 << 32) + n / 2) / n;
					verts = n;
				end
				step = 32'(stepw);
				for (longint unsigned i = 0; i < verts; i++) begin
					// odd star vertices sit on the inner radius
					r = (star && i[0]) ? longint'(inner) : longint'(outer);
					rotate(ang, c, s);
					vx = scale(r, c);
					vy = scale(r, s);
					if (i == 0 || vx < mnx) mnx = vx;
					if (i == 0 || vy < mny) mny = vy;
					if (i == 0 || vx > mxx) mxx = vx;
					if (i == 0 || vy > mxy) mxy = vy;
					ang = ang + step;
				end
				b.left = COORD_W'(mnx);
				b.top = COORD_W'(mny);
				b.width = COORD_W'(mxx - mnx);
				b.height = COORD_W'(mxy - mny);
			end
			pending_boxes.push_back(b);
		endfunction

		function void check_box(box_t got);
			box_t exp_b;
			if (pending_boxes.size() == 0) begin
				$display("%0t: unexpected result left=%0d top=%0d", $time, got.left, got.top);
				errors++;
				return;
			end
			exp_b = pending_boxes.pop_front();
			if (got.left !== exp_b.left) begin
				$display("%0t: box_left expected %0d got %0d", $time, exp_b.left, got.left);
				errors++;
			end
			if (got.top !== exp_b.top) begin
				$display("%0t: box_top expected %0d got %0d", $time, exp_b.top, got.top);
				errors++;
			end
			if (got.width !== exp_b.width) begin
				$display("%0t: box_width expected %0d got %0d", $time, exp_b.width, got.width);
				errors++;
			end
			if (got.height !== exp_b.height) begin
				$display("%0t: box_height expected %0d got %0d", $time, exp_b.height,
					got.height);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic is_star = 0;
	logic [PC_W-1:0] point_count = '0;
	logic signed [ROT_W-1:0] rotation_deg = '0;
	logic [RAD_W-1:0] outer_radius = '0;
	logic [RAD_W-1:0] inner_radius = '0;
	logic out_valid;
	logic out_ready = 0;
	coord_t box_left, box_top;
	logic [COORD_W-1:0] box_width, box_height;

	box_scoreboard sb = new();
	longint cycles = 0;
	logic calm = 0;

	star_polygon_bounding_box u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.is_star(is_star), .point_count(point_count), .rotation_deg(rotation_deg),
		.outer_radius(outer_radius), .inner_radius(inner_radius),
		.out_valid(out_valid), .out_ready(out_ready),
		.box_left(box_left), .box_top(box_top), .box_width(box_width),
		.box_height(box_height)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (arst_n && in_valid && in_ready)
			sb.note_shape(is_star, point_count, rotation_deg, outer_radius, inner_radius);
		if (arst_n && out_valid && out_ready)
			sb.check_box('{box_left, box_top, box_width, box_height});
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 36);
	end

	task automatic send_shape(logic star, logic [15:0] pc, logic signed [16:0] rot,
			logic [23:0] outer, logic [23:0] inner);
		while (!calm && $urandom_range(99) < 36)
			@(negedge clk);
		in_valid = 1;
		is_star = star;
		point_count = pc;
		rotation_deg = rot;
		outer_radius = outer;
		inner_radius = inner;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		in_valid = 0;
	endtask

	function automatic logic signed [16:0] any_rotation();
		return 17'($signed($urandom_range(92160)) - 46080);
	endfunction

	initial begin
		logic [15:0] pc;
		logic [23:0] ro;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// zero count, fractional and whole counts, largest counts, rotation and radius extremes
		send_shape(1'b1, 16'h0000, 17'sd0, 24'd1000, 24'd500);
		send_shape(1'b0, 16'h0000, -17'sd46080, 24'hFFFFFF, 24'hFFFFFF);
		send_shape(1'b0, 16'h0100, 17'sd0, 24'd25600, 24'd0);
		send_shape(1'b1, 16'h0001, 17'sd11520, 24'd25600, 24'd12800);
		send_shape(1'b1, 16'h0180, 17'sd0, 24'd25600, 24'd12800);
		send_shape(1'b0, 16'h0300, 17'sd0, 24'd25600, 24'hFFFFFF);
		send_shape(1'b1, 16'h0500, 17'sd0, 24'd25600, 24'd10240);
		send_shape(1'b0, 16'h0400, 17'sd5760, 24'hFFFFFF, 24'd0);
		send_shape(1'b1, 16'h0500, 17'sd46080, 24'hFFFFFF, 24'hFFFFFF);
		send_shape(1'b1, 16'h0500, -17'sd46080, 24'd0, 24'd0);
		send_shape(1'b0, 16'h0680, -17'sd1, 24'd1, 24'd1);
		send_shape(1'b1, 16'h0340, 17'sd23040, 24'd0, 24'hFFFFFF);
		send_shape(1'b0, 16'hFFFF, 17'sd100, 24'h800000, 24'd0);
		send_shape(1'b1, 16'hFFFF, 17'sd0, 24'd5000, 24'd2500);
		send_shape(1'b1, 16'hFF01, -17'sd300, 24'h7FFFFF, 24'h123456);
		send_shape(1'b0, 16'h0200, 17'sd0, 24'hFFFFFF, 24'hFFFFFF);
		for (int k = 0; k < NUM_RANDOM; k++) begin
			calm = (k >= 150 && k < 250);
			case ($urandom_range(99)) inside
				[0:2]: pc = 16'($urandom);
				[3:6]: pc = 16'h0000;
				[7:20]: pc = 16'($urandom_range(255));
				default: pc = 16'($urandom_range(16'h0C00));
			endcase
			ro = ($urandom_range(9) == 0) ? 24'hFFFFFF : 24'($urandom);
			send_shape(1'($urandom_range(1)), pc, any_rotation(), ro, 24'($urandom));
		end
		calm = 0;
		while (sb.pending_boxes.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
